[rtl/srfe_pkg.sv]
// ----------------------------------------------------------------------------
// srfe_pkg
// Types, codes and constants shared by the sensor reply field extractor.
// ----------------------------------------------------------------------------
package srfe_pkg;

    localparam int LINE_BYTES_MAX_DEF = 128;

    localparam int MAG_W     = 31;
    localparam int TOKEN_W   = 7;
    localparam int FIELD_W   = 6;
    localparam int MAXLEN_W  = 8;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [MAG_W-1:0]   MAG_MAX   = {MAG_W{1'b1}};
    localparam logic [TOKEN_W-1:0] TOKEN_SAT = 7'd64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FIELD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OXY_FIELD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PH_FIELD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;

    localparam logic [FIELD_W-1:0]  RST_TEMP_FIELD = 6'd8;
    localparam logic [FIELD_W-1:0]  RST_OXY_FIELD  = 6'd9;
    localparam logic [FIELD_W-1:0]  RST_PH_FIELD   = 6'd17;
    localparam logic [MAXLEN_W-1:0] RST_MAX_LINE   = 8'd128;
    localparam logic [TICK_W-1:0]   RST_TIMEOUT    = 16'd1500;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic sign;
        logic started;
        logic stopped;
    } t_tok_flags;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature_raw;
        logic signed [31:0] oxygen_raw;
        logic signed [31:0] ph_raw;
        logic               temperature_found;
        logic               oxygen_found;
        logic               ph_found;
        logic [1:0]         line_status;
    } t_out_item;

endpackage

[rtl/srfe_token_acc.sv]
// ----------------------------------------------------------------------------
// srfe_token_acc
// Next magnitude and flags of the current token for one non-separator byte.
// ----------------------------------------------------------------------------
module srfe_token_acc
    import srfe_pkg::*;
(
    input  logic [7:0]       i_byte,
    input  logic [MAG_W-1:0] i_acc,
    input  t_tok_flags       i_flags,
    output logic [MAG_W-1:0] o_acc,
    output t_tok_flags       o_flags
);

    logic             is_sign;
    logic             is_digit;
    logic [3:0]       digit;
    logic [MAG_W+3:0] acc_wide;
    logic [MAG_W+3:0] prod;

    assign is_sign  = (i_byte == CHAR_PLUS) || (i_byte == CHAR_MINUS);
    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign digit    = 4'(i_byte - CHAR_ZERO);
    assign acc_wide = {4'b0000, i_acc};
    // Times ten as two shifted copies.
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + {{MAG_W{1'b0}}, digit};

    always_comb begin
        o_acc   = i_acc;
        o_flags = i_flags;
        if (!i_flags.stopped) begin
            if (is_sign && !i_flags.started) begin
                o_flags.sign    = (i_byte == CHAR_MINUS);
                o_flags.started = 1'b1;
            end else if (is_digit) begin
                o_acc = (prod > {4'b0000, MAG_MAX}) ? MAG_MAX : prod[MAG_W-1:0];
                o_flags.started = 1'b1;
            end else begin
                o_flags.started = 1'b1;
                o_flags.stopped = 1'b1;
            end
        end
    end

endmodule

[rtl/sensor_reply_field_extractor_unit.sv]
// ----------------------------------------------------------------------------
// sensor_reply_field_extractor_unit
// Splits instrument reply lines into tokens and reports three numeric fields.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item is taken per cycle; line state updates in the cycle of acceptance.
// A result appears on the output register in the cycle after the item that ends
// the line. Input stalls only while a held result is itself stalled.
// Reset is synchronous and restores the register defaults and an empty line.
// ----------------------------------------------------------------------------
module sensor_reply_field_extractor_unit
    import srfe_pkg::*;
#(
    parameter int LINE_BYTES_MAX = LINE_BYTES_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(LINE_BYTES_MAX + 1);

    logic [FIELD_W-1:0]  r_pos [3];
    logic [MAXLEN_W-1:0] r_max_line;
    logic [TICK_W-1:0]   r_timeout;

    logic [TOKEN_W-1:0]  r_token, n_token;
    logic [CNT_W-1:0]    r_byte_cnt, n_byte_cnt;
    logic [TICK_W-1:0]   r_tick_cnt, n_tick_cnt;
    logic [MAG_W-1:0]    r_acc, n_acc;
    t_tok_flags          r_flags, n_flags;
    logic [31:0]         r_fval [3];
    logic [31:0]         n_fval [3];
    logic [2:0]          r_ffound, n_ffound;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                in_acc;
    logic                emit;
    logic                end_tok;
    logic [1:0]          status;
    logic [CNT_W-1:0]    limit;
    logic [CNT_W:0]      byte_next;
    logic [TICK_W:0]     tick_next;
    logic                is_sep;
    logic [31:0]         sval;
    logic [31:0]         fval_end [3];
    logic [2:0]          ffound_end;
    logic [MAG_W-1:0]    tok_acc;
    t_tok_flags          tok_flags;
    logic [31:0]         res_val [3];

    srfe_token_acc u_token_acc (
        .i_byte  (i_in_data.rx_byte),
        .i_acc   (r_acc),
        .i_flags (r_flags),
        .o_acc   (tok_acc),
        .o_flags (tok_flags)
    );

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign limit = ({1'b0, r_max_line} > (MAXLEN_W + 1)'(LINE_BYTES_MAX))
                 ? CNT_W'(LINE_BYTES_MAX) : r_max_line[CNT_W-1:0];
    assign byte_next = {1'b0, r_byte_cnt} + 1'b1;
    assign tick_next = {1'b0, r_tick_cnt} + 1'b1;
    assign is_sep    = (i_in_data.rx_byte == CHAR_SPACE) || (i_in_data.rx_byte == CHAR_LF);
    assign sval      = r_flags.sign ? (32'd0 - {1'b0, r_acc}) : {1'b0, r_acc};

    // Field values as they stand once the current token is closed.
    always_comb begin
        for (int f = 0; f < 3; f++) begin
            if ({1'b0, r_pos[f]} == r_token) begin
                fval_end[f]   = sval;
                ffound_end[f] = 1'b1;
            end else begin
                fval_end[f]   = r_fval[f];
                ffound_end[f] = r_ffound[f];
            end
        end
    end

    always_comb begin
        n_token    = r_token;
        n_byte_cnt = r_byte_cnt;
        n_tick_cnt = r_tick_cnt;
        n_acc      = r_acc;
        n_flags    = r_flags;
        n_fval     = r_fval;
        n_ffound   = r_ffound;
        emit       = 1'b0;
        end_tok    = 1'b0;
        status     = ST_COMPLETE;
        if (in_acc) begin
            if (i_in_data.cmd == CMD_TICK) begin
                if (tick_next > {1'b0, r_timeout}) begin
                    emit   = 1'b1;
                    status = ST_TIMEOUT;
                end else begin
                    n_tick_cnt = tick_next[TICK_W-1:0];
                end
            end else if (i_in_data.rx_byte == CHAR_CR) begin
                end_tok = 1'b1;
                emit    = 1'b1;
                status  = ST_COMPLETE;
            end else begin
                n_byte_cnt = byte_next[CNT_W-1:0];
                if (byte_next >= {1'b0, limit}) begin
                    emit   = 1'b1;
                    status = ST_TOO_LONG;
                end else if (is_sep) begin
                    end_tok = 1'b1;
                end else begin
                    n_acc   = tok_acc;
                    n_flags = tok_flags;
                end
            end
        end
        if (end_tok) begin
            n_fval   = fval_end;
            n_ffound = ffound_end;
            n_token  = (r_token < TOKEN_SAT) ? r_token + 1'b1 : r_token;
            n_acc    = '0;
            n_flags  = '0;
        end
        // Every result starts a fresh line.
        if (emit) begin
            n_token    = '0;
            n_byte_cnt = '0;
            n_tick_cnt = '0;
            n_acc      = '0;
            n_flags    = '0;
            n_ffound   = '0;
            for (int f = 0; f < 3; f++) begin
                n_fval[f] = '0;
            end
        end
    end

    always_comb begin
        for (int f = 0; f < 3; f++) begin
            res_val[f] = end_tok ? fval_end[f] : r_fval[f];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0]    <= RST_TEMP_FIELD;
            r_pos[1]    <= RST_OXY_FIELD;
            r_pos[2]    <= RST_PH_FIELD;
            r_max_line  <= RST_MAX_LINE;
            r_timeout   <= RST_TIMEOUT;
            r_token     <= '0;
            r_byte_cnt  <= '0;
            r_tick_cnt  <= '0;
            r_acc       <= '0;
            r_flags     <= '0;
            r_ffound    <= '0;
            r_out_valid <= 1'b0;
            for (int f = 0; f < 3; f++) begin
                r_fval[f] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TEMP_FIELD: r_pos[0]   <= i_cfg_data[FIELD_W-1:0];
                    CFG_OXY_FIELD:  r_pos[1]   <= i_cfg_data[FIELD_W-1:0];
                    CFG_PH_FIELD:   r_pos[2]   <= i_cfg_data[FIELD_W-1:0];
                    CFG_MAX_LINE:   r_max_line <= i_cfg_data[MAXLEN_W-1:0];
                    CFG_TIMEOUT:    r_timeout  <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            r_token    <= n_token;
            r_byte_cnt <= n_byte_cnt;
            r_tick_cnt <= n_tick_cnt;
            r_acc      <= n_acc;
            r_flags    <= n_flags;
            r_fval     <= n_fval;
            r_ffound   <= n_ffound;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.temperature_raw   <= res_val[0];
            r_out.oxygen_raw        <= res_val[1];
            r_out.ph_raw            <= res_val[2];
            r_out.temperature_found <= end_tok ? ffound_end[0] : r_ffound[0];
            r_out.oxygen_found      <= end_tok ? ffound_end[1] : r_ffound[1];
            r_out.ph_found          <= end_tok ? ffound_end[2] : r_ffound[2];
            r_out.line_status       <= status;
        end
    end

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_token == '0) && (r_byte_cnt == '0) && (r_tick_cnt == '0)
                 && (r_ffound == '0))
        else $error("line state not cleared after a result");

    a_byte_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_byte_cnt} < (CNT_W + 1)'(LINE_BYTES_MAX))
        else $error("byte count reached the line limit without a result");

    a_token_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token <= TOKEN_SAT)
        else $error("token index beyond saturation");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.line_status == ST_COMPLETE
                         || r_out.line_status == ST_TOO_LONG
                         || r_out.line_status == ST_TIMEOUT))
        else $error("illegal line status on a result");

endmodule

[tb/sv/tb_sensor_reply_field_extractor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_reply_field_extractor_unit
// Drives instrument reply lines, timer ticks and register writes into the
// field extractor. It predicts every line result and compares it field by
// field with what the block delivers, under random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_sensor_reply_field_extractor_unit;
    import srfe_pkg::*;

    localparam int IDLE_LIMIT      = 4000;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int PHASES          = 10;
    localparam int MIN_LINES       = 48;
    localparam int SHOWN_ERRORS    = 10;

    // Predicts line results and holds them until the block delivers them.
    class reply_scoreboard;
        logic [FIELD_W-1:0]  field_pos [3];
        logic [MAXLEN_W-1:0] max_line;
        logic [TICK_W-1:0]   timeout_lim;

        logic [TOKEN_W-1:0]  token_idx;
        logic [MAXLEN_W-1:0] byte_cnt;
        logic [TICK_W-1:0]   tick_cnt;
        logic [MAG_W-1:0]    mag;
        t_tok_flags          flags;
        logic [31:0]         field_val [3];
        logic                field_hit [3];

        t_out_item pending_lines [$];
        int        lines_made;
        int        mismatches;

        function new();
            field_pos[0] = RST_TEMP_FIELD;
            field_pos[1] = RST_OXY_FIELD;
            field_pos[2] = RST_PH_FIELD;
            max_line     = RST_MAX_LINE;
            timeout_lim  = RST_TIMEOUT;
            lines_made   = 0;
            mismatches   = 0;
            clear_line();
        endfunction

        function void clear_line();
            token_idx = '0;
            byte_cnt  = '0;
            tick_cnt  = '0;
            mag       = '0;
            flags     = '0;
            for (int f = 0; f < 3; f++) begin
                field_val[f] = '0;
                field_hit[f] = 1'b0;
            end
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_TEMP_FIELD: field_pos[0] = data[FIELD_W-1:0];
                CFG_OXY_FIELD:  field_pos[1] = data[FIELD_W-1:0];
                CFG_PH_FIELD:   field_pos[2] = data[FIELD_W-1:0];
                CFG_MAX_LINE:   max_line     = data[MAXLEN_W-1:0];
                CFG_TIMEOUT:    timeout_lim  = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void close_token();
            logic [31:0] v;
            v = {1'b0, mag};
            if (flags.sign) v = -v;
            for (int f = 0; f < 3; f++) begin
                if ({1'b0, field_pos[f]} == token_idx) begin
                    field_val[f] = v;
                    field_hit[f] = 1'b1;
                end
            end
            if (token_idx < TOKEN_SAT) token_idx++;
            mag   = '0;
            flags = '0;
        endfunction

        function void emit(logic [1:0] status);
            t_out_item r;
            r.temperature_raw   = field_hit[0] ? field_val[0] : '0;
            r.oxygen_raw        = field_hit[1] ? field_val[1] : '0;
            r.ph_raw            = field_hit[2] ? field_val[2] : '0;
            r.temperature_found = field_hit[0];
            r.oxygen_found      = field_hit[1];
            r.ph_found          = field_hit[2];
            r.line_status       = status;
            pending_lines.push_back(r);
            lines_made++;
            clear_line();
        endfunction

        function void note_item(t_in_item it);
            logic [TICK_W:0]     t;
            logic [MAXLEN_W-1:0] lim;
            logic [7:0]          c;
            logic [MAG_W+3:0]    prod;
            c = it.rx_byte;
            if (it.cmd == CMD_TICK) begin
                t = {1'b0, tick_cnt} + 1'b1;
                if (t > {1'b0, timeout_lim}) emit(ST_TIMEOUT);
                else tick_cnt = t[TICK_W-1:0];
                return;
            end
            if (c == CHAR_CR) begin
                close_token();
                emit(ST_COMPLETE);
                return;
            end
            lim = (max_line > LINE_BYTES_MAX_DEF) ? MAXLEN_W'(LINE_BYTES_MAX_DEF) : max_line;
            byte_cnt++;
            if (c == CHAR_SPACE || c == CHAR_LF) begin
                // A separator that hits the limit ends the line, not the token.
                if (byte_cnt >= lim) emit(ST_TOO_LONG);
                else close_token();
                return;
            end
            if (!flags.stopped) begin
                if ((c == CHAR_PLUS || c == CHAR_MINUS) && !flags.started) begin
                    if (c == CHAR_MINUS) flags.sign = 1'b1;
                    flags.started = 1'b1;
                end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    prod = (MAG_W+4)'(mag) * 10 + (MAG_W+4)'(c - CHAR_ZERO);
                    mag  = (prod > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
                    flags.started = 1'b1;
                end else begin
                    flags.stopped = 1'b1;
                    flags.started = 1'b1;
                end
            end
            if (byte_cnt >= lim) emit(ST_TOO_LONG);
        endfunction

        function void check_line(t_out_item got);
            t_out_item want;
            bit        bad;
            if (pending_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result: temp %0d oxy %0d ph %0d found %b%b%b status %0d",
                             got.temperature_raw, got.oxygen_raw, got.ph_raw,
                             got.temperature_found, got.oxygen_found, got.ph_found,
                             got.line_status);
                return;
            end
            want = pending_lines.pop_front();
            bad = (got.temperature_raw !== want.temperature_raw)
               || (got.oxygen_raw !== want.oxygen_raw)
               || (got.ph_raw !== want.ph_raw)
               || (got.temperature_found !== want.temperature_found)
               || (got.oxygen_found !== want.oxygen_found)
               || (got.ph_found !== want.ph_found)
               || (got.line_status !== want.line_status);
            if (bad) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("line mismatch at %0t", $realtime);
                    $display("  expected: temp %0d oxy %0d ph %0d found %b%b%b status %0d",
                             want.temperature_raw, want.oxygen_raw, want.ph_raw,
                             want.temperature_found, want.oxygen_found, want.ph_found,
                             want.line_status);
                    $display("  actual:   temp %0d oxy %0d ph %0d found %b%b%b status %0d",
                             got.temperature_raw, got.oxygen_raw, got.ph_raw,
                             got.temperature_found, got.oxygen_found, got.ph_found,
                             got.line_status);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    reply_scoreboard sb;
    t_in_item        line_q [$];
    int              tick_pct    = 0;
    bit              steady      = 1'b0;
    int              stall_left  = 0;
    int              quiet_left  = 0;
    int              idle_cycles = 0;

    sensor_reply_field_extractor_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item byte_item(logic [7:0] b);
        t_in_item it;
        it.cmd     = CMD_BYTE;
        it.rx_byte = b;
        return it;
    endfunction

    function automatic t_in_item tick_item();
        t_in_item it;
        it.cmd     = CMD_TICK;
        it.rx_byte = 8'($urandom);
        return it;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        line_q.push_back(byte_item(b));
        if ($urandom_range(0, 99) < tick_pct) line_q.push_back(tick_item());
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(byte_item(8'(s[i])));
    endfunction

    function automatic void put_junk();
        logic [7:0] b;
        do b = 8'($urandom);
        while (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_LF);
        put_byte(b);
    endfunction

    function automatic void put_separator();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (r < 95) ? 1 : $urandom_range(2, 4);
        for (int i = 0; i < n; i++)
            put_byte((r < 85 || ($urandom_range(0, 1) == 0 && r >= 95)) ? CHAR_SPACE : CHAR_LF);
    endfunction

    function automatic void put_token();
        int kind;
        int s;
        int nd;
        kind = $urandom_range(0, 9);
        s    = $urandom_range(0, 9);
        if (s < 3) put_byte(CHAR_MINUS);
        else if (s == 3) put_byte(CHAR_PLUS);
        if (kind < 6) nd = $urandom_range(1, 5);
        else if (kind < 8) nd = 0;
        else if (kind < 9) nd = $urandom_range(9, 12);
        else nd = $urandom_range(1, 3);
        for (int i = 0; i < nd; i++) put_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if (kind == 9 || $urandom_range(0, 19) == 0) begin
            put_junk();
            if ($urandom_range(0, 1) == 0) put_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // Mostly well formed reply lines with random content; the rest is noise,
    // tick bursts, overlong lines and long runs of separators.
    function automatic void build_line();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            n = $urandom_range(1, 22);
            for (int i = 0; i < n; i++) begin
                put_token();
                if (i < n - 1 || $urandom_range(0, 4) == 0) put_separator();
            end
            line_q.push_back(byte_item(CHAR_CR));
        end else if (r < 75) begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) put_byte(8'($urandom));
            if ($urandom_range(0, 1) == 0) line_q.push_back(byte_item(CHAR_CR));
        end else if (r < 85) begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                put_token();
                put_separator();
            end
            n = $urandom_range(1, 70);
            for (int i = 0; i < n; i++) line_q.push_back(tick_item());
        end else if (r < 93) begin
            while (line_q.size() < 140) begin
                put_token();
                put_separator();
            end
            line_q.push_back(byte_item(CHAR_CR));
        end else begin
            n = $urandom_range(58, 70);
            for (int i = 0; i < n; i++)
                put_byte(($urandom_range(0, 3) == 0) ? CHAR_LF : CHAR_SPACE);
            put_token();
            line_q.push_back(byte_item(CHAR_CR));
        end
    endfunction

    function automatic logic [FIELD_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return FIELD_W'($urandom_range(0, 12));
        if (r < 85) return FIELD_W'($urandom_range(13, 24));
        return FIELD_W'($urandom_range(56, 63));
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk);
        while (in_stall);
        sb.note_item(it);
    endtask

    task automatic send_line();
        steady = ($urandom_range(0, 7) == 0);
        foreach (line_q[i]) send_item(line_q[i]);
        line_q.delete();
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk);
        while (!cfg_ready);
        sb.apply_write(idx, data);
    endtask

    // Unused upper data bits get random values; the block keeps only the
    // register width.
    task automatic set_config(logic [FIELD_W-1:0] t_pos, logic [FIELD_W-1:0] o_pos,
                              logic [FIELD_W-1:0] p_pos, logic [MAXLEN_W-1:0] max_len,
                              logic [TICK_W-1:0] ticks);
        write_reg(CFG_TEMP_FIELD, {(CFG_DAT_W-FIELD_W)'($urandom), t_pos});
        write_reg(CFG_OXY_FIELD,  {(CFG_DAT_W-FIELD_W)'($urandom), o_pos});
        write_reg(CFG_PH_FIELD,   {(CFG_DAT_W-FIELD_W)'($urandom), p_pos});
        write_reg(CFG_MAX_LINE,   {(CFG_DAT_W-MAXLEN_W)'($urandom), max_len});
        write_reg(CFG_TIMEOUT,    ticks);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_lines.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk) begin : out_side
        int n;
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_line(out_data);
            if (stall_left > 0) begin
                stall_left--;
            end else begin
                if (quiet_left > 0) quiet_left--;
                else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(50, 200);
                n = pick_gap(quiet_left > 0);
                if (n > 0) begin
                    out_stall  <= 1'b1;
                    stall_left = n - 1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no handshake for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int sent;
        logic [MAXLEN_W-1:0] max_len;
        logic [TICK_W-1:0]   ticks;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset positions: temperature after eight separators, oxygen ended
        // by the carriage return, pH never reached.
        put_text("        -7 5");
        line_q.push_back(byte_item(CHAR_CR));
        send_line();
        in_valid <= 1'b0;
        wait_drained();

        // Oxygen and pH share a position; the first token saturates and a
        // sign after a digit stops the second one.
        set_config(6'd0, 6'd1, 6'd1, 8'd128, 16'd3);
        put_text("9999999999 3-4");
        line_q.push_back(byte_item(CHAR_CR));
        // The pending token is lost when the fourth tick times out.
        put_text("5 6");
        repeat (4) line_q.push_back(tick_item());
        send_line();
        in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if ($urandom_range(0, 3) == 0) max_len = MAXLEN_W'($urandom_range(129, 255));
            else max_len = MAXLEN_W'($urandom_range(2, 128));
            ticks = ($urandom_range(0, 3) == 0) ? RST_TIMEOUT : TICK_W'($urandom_range(2, 80));
            case (p)
                0: set_config(RST_TEMP_FIELD, RST_OXY_FIELD, RST_PH_FIELD,
                              RST_MAX_LINE, RST_TIMEOUT);
                1: set_config(pick_pos(), pick_pos(), pick_pos(), 8'd1, 16'hFFFF);
                2: set_config(pick_pos(), pick_pos(), pick_pos(), 8'hFF, 16'd0);
                3: set_config(pick_pos(), pick_pos(), pick_pos(), 8'd0, 16'd1);
                4: set_config(6'd63, 6'd0, 6'd63, 8'd128, RST_TIMEOUT);
                default: set_config(pick_pos(), pick_pos(), pick_pos(), max_len, ticks);
            endcase
            if (p == 5) begin
                // Writes to indexes past the last register must change nothing.
                for (int i = CFG_TIMEOUT + 1; i < 2 ** CFG_IDX_W; i++)
                    write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
                cfg_valid <= 1'b0;
            end
            tick_pct = $urandom_range(0, 8);
            sent = 0;
            while (sent < ITEMS_PER_PHASE || (p == PHASES - 1 && sb.lines_made < MIN_LINES)) begin
                build_line();
                sent += line_q.size();
                send_line();
            end
            // Close the line so that the next settings start from a clean one.
            line_q.push_back(byte_item(CHAR_CR));
            send_line();
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_lines.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
